[hdl/hrlf_pkg.sv]
package hrlf_pkg;

    localparam int COUNT_WIDTH = 25;
    localparam int CAP_WIDTH   = 25;
    localparam int LEN_WIDTH   = 32;
    localparam int NAME_LEN    = 15;
    localparam int MATCH_WIDTH = $clog2(NAME_LEN + 1);

    localparam logic [CAP_WIDTH-1:0]   CAP_RESET       = CAP_WIDTH'(65536);
    localparam logic [31:0]            HEADER_END_WORD = 32'h0D0A_0D0A;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX       = '1;
    localparam logic [LEN_WIDTH-1:0]   LEN_MAX         = '1;

    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_BLANK = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // Lowercase text of the length header name, one character per position.
    function automatic logic [7:0] name_char(input logic [MATCH_WIDTH-1:0] idx);
        logic [7:0] c;
        case (idx)
            MATCH_WIDTH'(0):  c = "c";
            MATCH_WIDTH'(1):  c = "o";
            MATCH_WIDTH'(2):  c = "n";
            MATCH_WIDTH'(3):  c = "t";
            MATCH_WIDTH'(4):  c = "e";
            MATCH_WIDTH'(5):  c = "n";
            MATCH_WIDTH'(6):  c = "t";
            MATCH_WIDTH'(7):  c = "-";
            MATCH_WIDTH'(8):  c = "l";
            MATCH_WIDTH'(9):  c = "e";
            MATCH_WIDTH'(10): c = "n";
            MATCH_WIDTH'(11): c = "g";
            MATCH_WIDTH'(12): c = "t";
            MATCH_WIDTH'(13): c = "h";
            MATCH_WIDTH'(14): c = ":";
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hdl/http_response_length_framer.sv]
// Channel   | Direction | Signals
// ----------+-----------+--------------------------------------------------------
// input     | in        | i_in_valid / o_in_ready, i_data_byte, i_stream_closed
// result    | out       | o_out_valid / i_out_ready, o_response_done, o_close_needed,
//           |           | o_header_complete, o_length_found, o_content_length,
//           |           | o_bytes_received
// config    | in        | i_cfg_valid / o_cfg_ready, i_cfg_buffer_capacity
//
// One request is taken per cycle while o_in_ready is high; its result is loaded into
// the output register at acceptance. The rate is set by the per-byte state update,
// which is one register stage of short logic (times-ten add, two compares).
// o_in_ready follows the output register: a new request is taken while it is empty or
// while its finished result is being taken in the same cycle.
// Sync active-low reset clears framing state and o_out_valid, loads capacity 65536.
module http_response_length_framer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_stream_closed,

    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_response_done,
    output logic                            o_close_needed,
    output logic                            o_header_complete,
    output logic                            o_length_found,
    output logic [hrlf_pkg::LEN_WIDTH-1:0]  o_content_length,
    output logic [hrlf_pkg::CAP_WIDTH-1:0]  o_bytes_received,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hrlf_pkg::CAP_WIDTH-1:0]  i_cfg_buffer_capacity
);
    import hrlf_pkg::*;

    // Framing state of the response in progress.
    logic [CAP_WIDTH-1:0]   r_capacity;
    logic [COUNT_WIDTH-1:0] r_byte_total,  n_byte_total;
    logic [31:0]            r_tail,        n_tail;
    logic                   r_header_seen, n_header_seen;
    logic [MATCH_WIDTH-1:0] r_match,       n_match;
    t_phase                 r_phase,       n_phase;
    logic [LEN_WIDTH-1:0]   r_len,         n_len;
    logic                   r_len_valid,   n_len_valid;
    logic [LEN_WIDTH-1:0]   r_body,        n_body;
    logic                   r_close,       n_close;
    logic                   n_done;

    // Result register.
    logic                   r_out_valid;
    logic                   r_done, r_close_o, r_hdr_o, r_lenv_o;
    logic [LEN_WIDTH-1:0]   r_len_o;
    logic [CAP_WIDTH-1:0]   r_bytes_o;

    logic                   accept;
    logic [7:0]             lc;
    logic [MATCH_WIDTH-1:0] match_inc;
    logic                   is_digit, is_blank, header_now, cap_hit;
    logic [LEN_WIDTH+3:0]   times_ten;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;

    assign lc        = (i_data_byte inside {["A":"Z"]}) ? i_data_byte + 8'd32 : i_data_byte;
    assign is_digit  = i_data_byte inside {["0":"9"]};
    assign is_blank  = (i_data_byte == " ") || (i_data_byte == 8'h09);
    assign match_inc = r_match + MATCH_WIDTH'(1);
    // length * 10 + digit, wide enough to see overflow
    assign times_ten = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1)
                       + {{(LEN_WIDTH){1'b0}}, i_data_byte[3:0]};

    always_comb begin
        n_byte_total  = r_byte_total;
        n_tail        = r_tail;
        n_header_seen = r_header_seen;
        n_match       = r_match;
        n_phase       = r_phase;
        n_len         = r_len;
        n_len_valid   = r_len_valid;
        n_body        = r_body;
        n_close       = r_close;
        n_done        = 1'b0;
        header_now    = 1'b0;
        cap_hit       = 1'b0;

        if (i_stream_closed) begin
            n_done  = 1'b1;
            n_close = 1'b1;
        end else begin
            if (r_byte_total != COUNT_MAX) begin
                n_byte_total = r_byte_total + COUNT_WIDTH'(1);
            end

            if (!r_header_seen) begin
                n_tail = {r_tail[23:0], i_data_byte};

                // Scan for the first length header and its digits.
                case (r_phase)
                    PH_NAME: begin
                        if (r_match < MATCH_WIDTH'(NAME_LEN) && lc == name_char(r_match)) begin
                            n_match = match_inc;
                        end else begin
                            n_match = (lc == name_char(MATCH_WIDTH'(0)))
                                      ? MATCH_WIDTH'(1) : MATCH_WIDTH'(0);
                        end
                        if (n_match >= MATCH_WIDTH'(NAME_LEN)) begin
                            n_match = MATCH_WIDTH'(NAME_LEN);
                            n_phase = PH_BLANK;
                        end
                    end
                    PH_BLANK, PH_DIGIT: begin
                        if (r_phase == PH_BLANK && is_blank) begin
                            n_phase = PH_BLANK;
                        end else if (is_digit) begin
                            n_len       = (|times_ten[LEN_WIDTH+3:LEN_WIDTH])
                                          ? LEN_MAX : times_ten[LEN_WIDTH-1:0];
                            n_len_valid = 1'b1;
                            n_phase     = PH_DIGIT;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase

                if (n_tail == HEADER_END_WORD) begin
                    n_header_seen = 1'b1;
                    header_now    = 1'b1;
                    if (!n_len_valid) begin
                        n_close = 1'b1;
                    end
                end
            end

            if (r_header_seen && r_body != LEN_MAX) begin
                n_body = r_body + LEN_WIDTH'(1);
            end

            // The header end byte is never a digit, so the registered length holds here.
            cap_hit = (33'(n_byte_total) >= 33'(r_capacity))
                      || (n_byte_total == COUNT_MAX);
            if ((r_header_seen || header_now) && r_len_valid && n_body >= r_len) begin
                n_done = 1'b1;
            end else if (cap_hit) begin
                n_done  = 1'b1;
                n_close = 1'b1;
            end
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_buffer_capacity;
        end
    end

    // Framing state: advance per request, clear at the end of a response.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && n_done)) begin
            r_byte_total  <= '0;
            r_tail        <= '0;
            r_header_seen <= 1'b0;
            r_match       <= '0;
            r_phase       <= PH_NAME;
            r_len         <= '0;
            r_len_valid   <= 1'b0;
            r_body        <= '0;
            r_close       <= 1'b0;
        end else if (accept) begin
            r_byte_total  <= n_byte_total;
            r_tail        <= n_tail;
            r_header_seen <= n_header_seen;
            r_match       <= n_match;
            r_phase       <= n_phase;
            r_len         <= n_len;
            r_len_valid   <= n_len_valid;
            r_body        <= n_body;
            r_close       <= n_close;
        end
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_done    <= n_done;
            r_close_o <= n_close;
            r_hdr_o   <= n_header_seen;
            r_lenv_o  <= n_len_valid;
            r_len_o   <= n_len;
            r_bytes_o <= CAP_WIDTH'(n_byte_total);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_response_done   = r_done;
    assign o_close_needed    = r_close_o;
    assign o_header_complete = r_hdr_o;
    assign o_length_found    = r_lenv_o;
    assign o_content_length  = r_len_o;
    assign o_bytes_received  = r_bytes_o;

endmodule

[dv/http_response_length_framer_test.sv]
module http_response_length_framer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrlf_pkg::*;

    // Status the framer reports for every request, in port order.
    typedef struct packed {
        logic                 done;
        logic                 close;
        logic                 header;
        logic                 length_ok;
        logic [LEN_WIDTH-1:0] length;
        logic [CAP_WIDTH-1:0] received;
    } t_status;

    // One row of stimulus: either a capacity write or a byte/close request.
    // A typed row carries its expected status; all others go through the predictor.
    typedef struct {
        logic                 cap_write;
        logic [CAP_WIDTH-1:0] cap_value;
        logic [7:0]           data;
        logic                 closed;
        logic                 typed;
        t_status              want;
    } t_request;

    localparam logic [8*NAME_LEN-1:0] LEN_NAME_TEXT = "content-length:";
    localparam string                 EOL           = "\015\012";

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_data_byte;
    logic                 i_stream_closed;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_response_done;
    logic                 o_close_needed;
    logic                 o_header_complete;
    logic                 o_length_found;
    logic [LEN_WIDTH-1:0] o_content_length;
    logic [CAP_WIDTH-1:0] o_bytes_received;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CAP_WIDTH-1:0] i_cfg_buffer_capacity;

    http_response_length_framer dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_data_byte           (i_data_byte),
        .i_stream_closed       (i_stream_closed),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_response_done       (o_response_done),
        .o_close_needed        (o_close_needed),
        .o_header_complete     (o_header_complete),
        .o_length_found        (o_length_found),
        .o_content_length      (o_content_length),
        .o_bytes_received      (o_bytes_received),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_buffer_capacity (i_cfg_buffer_capacity)
    );

    always #5ns i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Framer state as the testbench sees it.
    // ------------------------------------------------------------------
    logic [CAP_WIDTH-1:0]   cap_now = CAP_RESET;
    logic [COUNT_WIDTH-1:0] byte_cnt;
    logic [31:0]            tail_bytes;
    logic                   hdr_done;
    int                     match_len;
    t_phase                 phase;
    logic [LEN_WIDTH-1:0]   len_value;
    logic                   len_seen;
    logic [LEN_WIDTH-1:0]   body_cnt;
    logic                   must_close;

    t_status  status_due[$];   // expected status, oldest first
    t_request request_q[$];    // stimulus rows still to be driven
    t_request cur_request;     // row currently offered on the input channel
    int       fail_count = 0;
    bit       no_gaps    = 1'b0;
    int       stall_left = 0;

    function automatic void clear_framer();
        byte_cnt   = '0;
        tail_bytes = '0;
        hdr_done   = 1'b0;
        match_len  = 0;
        phase      = PH_NAME;
        len_value  = '0;
        len_seen   = 1'b0;
        body_cnt   = '0;
        must_close = 1'b0;
    endfunction

    // Advance the header search by one byte: name match, blank skip, digits.
    function automatic void scan_header(logic [7:0] b);
        logic [7:0]  lc;
        int          idx;
        logic [63:0] grown;
        if (phase == PH_NAME) begin
            lc  = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            idx = match_len;
            if (idx < NAME_LEN && lc == LEN_NAME_TEXT[8*(NAME_LEN-1-idx) +: 8]) begin
                idx++;
            end else begin
                // a mismatch may still open a fresh match on the first letter
                idx = (lc == LEN_NAME_TEXT[8*(NAME_LEN-1) +: 8]) ? 1 : 0;
            end
            if (idx >= NAME_LEN) begin
                match_len = NAME_LEN;
                phase     = PH_BLANK;
            end else begin
                match_len = idx;
            end
        end else if (phase == PH_BLANK && (b == " " || b == "\t")) begin
            // skip blanks between the name and the value
        end else if (phase == PH_BLANK || phase == PH_DIGIT) begin
            if (b >= "0" && b <= "9") begin
                grown     = 64'(len_value) * 64'd10 + 64'(b - "0");
                len_value = (grown > 64'(LEN_MAX)) ? LEN_MAX : grown[LEN_WIDTH-1:0];
                len_seen  = 1'b1;
                phase     = PH_DIGIT;
            end else begin
                phase = PH_DONE;
            end
        end
    endfunction

    // Work out the status one accepted request produces, then clear on done.
    function automatic t_status advance_framer(logic [7:0] b, logic closed);
        t_status s;
        logic    ended;
        logic    header_now;
        ended      = 1'b0;
        header_now = 1'b0;
        if (closed) begin
            ended      = 1'b1;
            must_close = 1'b1;
        end else begin
            if (byte_cnt != COUNT_MAX) byte_cnt++;
            if (!hdr_done) begin
                tail_bytes = {tail_bytes[23:0], b};
                scan_header(b);
                if (tail_bytes == HEADER_END_WORD) begin
                    hdr_done   = 1'b1;
                    header_now = 1'b1;
                    if (!len_seen) must_close = 1'b1;
                end
            end
            if (hdr_done && !header_now && body_cnt != LEN_MAX) body_cnt++;
            // a complete body wins over capacity on the same byte
            if (hdr_done && len_seen && body_cnt >= len_value) begin
                ended = 1'b1;
            end else if (byte_cnt >= cap_now || byte_cnt == COUNT_MAX) begin
                ended      = 1'b1;
                must_close = 1'b1;
            end
        end
        s.done      = ended;
        s.close     = must_close;
        s.header    = hdr_done;
        s.length_ok = len_seen;
        s.length    = len_value;
        s.received  = byte_cnt;
        if (ended) clear_framer();
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, check results.
    // ------------------------------------------------------------------
    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= 200)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        t_status guess;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (status_due.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result with no request pending, expected none, actual %0d/%0d",
                             $time, o_response_done, o_bytes_received);
                end else begin
                    want = status_due.pop_front();
                    check_field("response_done",   32'(want.done),      32'(o_response_done));
                    check_field("close_needed",    32'(want.close),     32'(o_close_needed));
                    check_field("header_complete", 32'(want.header),    32'(o_header_complete));
                    check_field("length_found",    32'(want.length_ok), 32'(o_length_found));
                    check_field("content_length",  32'(want.length),    32'(o_content_length));
                    check_field("bytes_received",  32'(want.received),  32'(o_bytes_received));
                end
            end
            if (i_cfg_valid && o_cfg_ready) cap_now = i_cfg_buffer_capacity;
            if (i_in_valid && o_in_ready) begin
                // always advance the predictor; a typed row overrides its answer
                guess = advance_framer(i_data_byte, i_stream_closed);
                status_due.push_back(cur_request.typed ? cur_request.want : guess);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drop ready at random, hold off for a long stretch on demand.
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (no_gaps) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic t_request plain_byte(logic [7:0] b, logic closed);
        t_request r;
        r.cap_write = 1'b0;
        r.cap_value = '0;
        r.data      = b;
        r.closed    = closed;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic t_request typed_byte(logic [7:0] b, logic closed, t_status want);
        t_request r;
        r       = plain_byte(b, closed);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic t_request cap_row(logic [CAP_WIDTH-1:0] v);
        t_request r;
        r           = plain_byte(8'h00, 1'b0);
        r.cap_write = 1'b1;
        r.cap_value = v;
        return r;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) request_q.push_back(plain_byte(s[i], 1'b0));
    endfunction

    function automatic void add_body(int n);
        repeat (n) request_q.push_back(plain_byte(8'($urandom), 1'b0));
    endfunction

    function automatic void add_close();
        request_q.push_back(plain_byte(8'($urandom), 1'b1));
    endfunction

    // Flip the case of letters at random; the name match ignores case.
    function automatic string mixed_case(string s);
        string      t;
        logic [7:0] c;
        t = s;
        for (int i = 0; i < t.len(); i++) begin
            c = t[i];
            if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(1))
                t[i] = c ^ 8'h20;
        end
        return t;
    endfunction

    function automatic string random_word(int n, int lo, int hi);
        string t;
        t = "";
        repeat (n) t = $sformatf("%s%c", t, 8'($urandom_range(hi, lo)));
        return t;
    endfunction

    function automatic string blanks();
        string t;
        t = "";
        repeat ($urandom_range(3)) t = $sformatf("%s%c", t, $urandom_range(1) ? 8'h20 : 8'h09);
        return t;
    endfunction

    function automatic void add_fillers(int n);
        repeat (n)
            add_text({"X-", mixed_case(random_word($urandom_range(6, 1), "a", "z")), ": ",
                      random_word($urandom_range(8), 32, 126), EOL});
    endfunction

    // Append one response of a random shape: mostly well framed, the rest
    // saturating, lengthless, repeated names, near misses, noise and closes.
    function automatic void compose_response();
        int    shape;
        int    len;
        string val;
        shape = $urandom_range(99);
        if (shape >= 94) begin
            add_close();
            return;
        end
        if (shape >= 86) begin
            add_body($urandom_range(40, 8));
            if ($urandom_range(1)) add_close();
            return;
        end
        add_text({mixed_case("HTTP/1.1 200 OK"), EOL});
        add_fillers($urandom_range(2));
        len = ($urandom_range(9) == 0) ? $urandom_range(400) : $urandom_range(30);
        val = $sformatf("%0d", len);
        if ($urandom_range(3) == 0) val = {"00", val};
        if (shape < 50) begin
            add_text({mixed_case("Content-Length:"), blanks(), val, EOL});
            add_fillers($urandom_range(2));
            add_text(EOL);
            if ($urandom_range(9) == 0) begin
                add_body($urandom_range(len));
                add_close();
            end else begin
                add_body(len);
            end
        end else if (shape < 60) begin
            case ($urandom_range(4))
                0:       val = "4294967295";
                1:       val = "4294967296";
                2:       val = "18446744073709551616";
                3:       val = "000000000004294967294";
                default: val = "99999999999";
            endcase
            add_text({mixed_case("content-length:"), blanks(), val, EOL, EOL});
            add_body($urandom_range(20));
            add_close();
        end else if (shape < 70) begin
            // no length at all: only capacity or close can end it
            add_text(EOL);
            add_body($urandom_range(20));
            add_close();
        end else if (shape < 78) begin
            // the first name has no digits, so the second one must not count
            add_text({mixed_case("Content-Length:"), blanks(), "x1", EOL});
            add_text({"Content-Length: 5", EOL, EOL});
            add_body($urandom_range(10));
            add_close();
        end else begin
            case ($urandom_range(4))
                0:       add_text({"Content-Lengt: 7", EOL});
                1:       add_text({"Content-Length 7", EOL});
                2:       add_text({"Content_Length: 7", EOL});
                3:       add_text({"content-content-length: 2", EOL});
                default: add_text({"X-Content-Length: 4", EOL});
            endcase
            add_text({mixed_case("Content-Length:"), blanks(), val, EOL, EOL});
            add_body(len);
            if ($urandom_range(1)) add_close();
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers: change inputs at the falling edge, wait for the handshake.
    // ------------------------------------------------------------------
    task automatic send_request(t_request r);
        while (!no_gaps && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_request = r;
        i_in_valid      <= 1'b1;
        i_data_byte     <= r.data;
        i_stream_closed <= r.closed;
        // hold the request until the block takes it
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_WIDTH-1:0] v);
        // drain every outstanding result before touching the register
        i_in_valid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        i_cfg_valid           <= 1'b1;
        i_cfg_buffer_capacity <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_queue();
        t_request r;
        while (request_q.size() != 0) begin
            r = request_q.pop_front();
            if (r.cap_write) write_capacity(r.cap_value);
            else             send_request(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int                   target;
        logic [CAP_WIDTH-1:0] cap;
        i_rst_n               = 1'b0;
        i_in_valid            = 1'b0;
        i_data_byte           = 8'h00;
        i_stream_closed       = 1'b0;
        i_cfg_valid           = 1'b0;
        i_cfg_buffer_capacity = '0;
        clear_framer();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table. Peer close straight out of reset.
        request_q.push_back(typed_byte(8'hFF, 1'b1, t_status'{1'b1, 1'b1, 1'b0, 1'b0, '0, '0}));
        // Capacity zero behaves as one: the first byte ends the response.
        request_q.push_back(cap_row('0));
        request_q.push_back(typed_byte(8'h00, 1'b0, t_status'{1'b1, 1'b1, 1'b0, 1'b0, '0, 25'd1}));
        // Length and capacity land on the same byte: the length wins, no close.
        request_q.push_back(cap_row(25'd22));
        add_text({"cOnTeNt-LeNgTh:\t1", EOL, EOL, "Z"});
        request_q[$].typed = 1'b1;
        request_q[$].want  = t_status'{1'b1, 1'b0, 1'b1, 1'b1, 32'd1, 25'd22};
        run_queue();

        // Random phases, each under its own capacity.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin cap = 25'd16777216; target = 260; end
                1:       begin cap = 25'd60;       target = 260; end
                2:       begin cap = 25'd1;        target = 90;  end
                3:       begin cap = CAP_RESET;    target = 260; end
                4:       begin cap = 25'd300;      target = 300; end
                default: begin cap = 25'd37;       target = 260; end
            endcase
            no_gaps = (p == 3);
            request_q.push_back(cap_row(cap));
            run_queue();
            // back up the block while the sender keeps offering
            if (p == 1) stall_left = 400;
            while (request_q.size() < target) compose_response();
            add_close();
            run_queue();
        end
        no_gaps = 1'b0;
        i_in_valid <= 1'b0;

        while (status_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/hrlf_pkg.sv
hdl/http_response_length_framer.sv
dv/http_response_length_framer_test.sv
